>>> rtl/core/k_nearest_sorted_list_core_assert.svh
// Assertion macros for the k-nearest sorted list core.
`ifndef K_NEAREST_SORTED_LIST_CORE_ASSERT_SVH
`define K_NEAREST_SORTED_LIST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define KNSL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("knsl assertion failed");
`define KNSL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("knsl assertion failed");
`else
`define KNSL_ASSERT(lbl, clk, rst_n, prop)
`define KNSL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/knsl_pkg.sv
// Shared constants and types of the k-nearest sorted list core.
package knsl_pkg;

    localparam int KMAX_DEF       = 16;
    localparam int DIMS_DEF       = 3;
    localparam int COORD_BITS_DEF = 16;

    localparam int ID_W      = 16;
    localparam int DIST_W    = 36;
    localparam int RANK_W    = 4;
    localparam int KUSED_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int QUERY_NUM = 3;

    localparam logic [KUSED_W-1:0] KUSED_RST = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_0,
        CFG_QUERY_1,
        CFG_QUERY_2,
        CFG_K_USED
    } t_cfg_reg;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dist_sq;
    } t_entry;

    typedef struct packed {
        logic            first;
        logic            last;
        logic [ID_W-1:0] id;
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [DIST_W-1:0] dist_sq;
    } t_cand;

endpackage

>>> rtl/core/knsl_dist_lane.sv
// One coordinate lane: difference to the query, magnitude, square.
module knsl_dist_lane #(
    parameter int COORD_BITS = knsl_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [COORD_BITS-1:0]   i_coord,
    input  logic [COORD_BITS-1:0]   i_query,
    output logic [2*COORD_BITS-1:0] o_sq
);

    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS-1:0]      n_mag;
    logic [COORD_BITS-1:0]      r_mag;
    logic [2*COORD_BITS-1:0]    n_sq;
    logic [2*COORD_BITS-1:0]    r_sq;

    always_comb begin
        diff  = $signed({i_coord[COORD_BITS-1], i_coord})
              - $signed({i_query[COORD_BITS-1], i_query});
        n_mag = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
        n_sq  = r_mag * r_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
            r_sq  <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

>>> rtl/core/knsl_sorted_list.sv
// Sorted top-k list: parallel compare and shift insert, one candidate per cycle while i_step is high.
module knsl_sorted_list #(
    parameter int KMAX = knsl_pkg::KMAX_DEF,
    localparam int KW  = $clog2(KMAX + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  knsl_pkg::t_cand                  i_cand,
    input  logic [KW-1:0]                    i_k,
    output knsl_pkg::t_entry [KMAX-1:0]      o_list,
    output logic [KW-1:0]                    o_fill
);

    knsl_pkg::t_entry [KMAX-1:0] r_list;
    knsl_pkg::t_entry [KMAX-1:0] n_list;
    knsl_pkg::t_entry [KMAX-1:0] sh;
    logic [KW-1:0]               r_fill;
    logic [KW-1:0]               n_fill;
    logic [KW-1:0]               n_cnt;
    logic [KW-1:0]               limit;
    logic [KMAX-1:0]             vld;
    logic [KMAX-1:0]             le;
    logic [KMAX-1:0]             le_prev;
    logic                        full;
    logic                        ins;
    knsl_pkg::t_entry            e_new;

    always_comb begin
        e_new.id      = i_cand.tag.id;
        e_new.dist_sq = i_cand.dist_sq;
        n_cnt = i_cand.tag.first ? '0 : ((r_fill > i_k) ? i_k : r_fill);
        full  = (n_cnt == i_k);
        for (int j = 0; j < KMAX; j++) begin
            vld[j] = (KW'(j) < n_cnt);
            le[j]  = vld[j] && (r_list[j].dist_sq <= i_cand.dist_sq);
        end
        le_prev = KMAX'({le, 1'b1});
        ins     = !(full && (&(le | ~vld)));
        limit   = full ? KW'(i_k - 1'b1) : n_cnt;
        sh[0]   = e_new;
        for (int j = 1; j < KMAX; j++) begin
            sh[j] = r_list[j-1];
        end
        for (int j = 0; j < KMAX; j++) begin
            if (!ins || le[j]) begin
                n_list[j] = r_list[j];
            end else if (le_prev[j]) begin
                n_list[j] = e_new;
            end else if (KW'(j) <= limit) begin
                n_list[j] = sh[j];
            end else begin
                n_list[j] = r_list[j];
            end
        end
        n_fill = (ins && !full) ? KW'(n_cnt + 1'b1) : n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_step) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_list <= n_list;
        end
    end

    assign o_list = n_list;
    assign o_fill = n_fill;

endmodule

>>> rtl/core/knsl_emit.sv
// Output buffer: snapshot of the list, shifted out one entry per transfer.
`include "k_nearest_sorted_list_core_assert.svh"

module knsl_emit #(
    parameter int KMAX = knsl_pkg::KMAX_DEF,
    localparam int KW  = $clog2(KMAX + 1),
    localparam int IW  = (KMAX > 1) ? $clog2(KMAX) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  knsl_pkg::t_entry [KMAX-1:0]     i_list,
    input  logic [KW-1:0]                   i_count,
    output logic                            o_busy,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [knsl_pkg::RANK_W-1:0]     o_rank,
    output logic [knsl_pkg::ID_W-1:0]       o_id,
    output logic [knsl_pkg::DIST_W-1:0]     o_dist,
    output logic                            o_end
);

    knsl_pkg::t_entry [KMAX-1:0] r_buf;
    logic [KW-1:0]               r_left;
    logic [IW-1:0]               r_rank;
    logic                        xfer;

    assign xfer = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_rank <= '0;
        end else if (i_load) begin
            r_left <= i_count;
            r_rank <= '0;
        end else if (xfer) begin
            r_left <= KW'(r_left - 1'b1);
            r_rank <= IW'(r_rank + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_list;
        end else if (xfer) begin
            for (int j = 0; j < KMAX - 1; j++) begin
                r_buf[j] <= r_buf[j+1];
            end
        end
    end

    assign o_busy  = (r_left != '0);
    assign o_valid = o_busy;
    assign o_rank  = knsl_pkg::RANK_W'(r_rank);
    assign o_id    = r_buf[0].id;
    assign o_dist  = r_buf[0].dist_sq;
    assign o_end   = (r_left == KW'(1));

    `KNSL_ASSERT(a_load_when_idle, i_clk, i_rst_n, i_load |-> !o_busy)
    `KNSL_ASSERT(a_end_drains, i_clk, i_rst_n, (xfer && o_end && !i_load) |=> !o_valid)
    `KNSL_ASSERT(a_rank_steps, i_clk, i_rst_n, (xfer && !o_end) |=> (o_valid && (o_rank == 4'($past(o_rank) + 4'd1))))
    `KNSL_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)

endmodule

>>> rtl/core/k_nearest_sorted_list_core.sv
// Top level of the k-nearest sorted list core.
//
//  channel   | dir | contents (low bit up)
//  s_axis    | in  | tdata: point_id, coord_0..coord_DIMS-1; tuser: first; tlast: last
//  m_axis    | out | tdata: rank, neighbour_id, distance_sq; tlast: end_of_run
//  cfg       | in  | write enable, index (query_0, query_1, query_2, k_used), data
//
// One candidate per cycle unless the input stalls; the list takes it through
// registers (coordinate lanes: magnitude, square; sum with saturation; list insert).
// A candidate with last hands the list to the output buffer, which sends
// fill-count entries, one per cycle while m_axis_tready is high.
// Input stalls only when a last candidate reaches the list while the
// previous list is still being sent. Reset empties the list and the buffer.
module k_nearest_sorted_list_core #(
    parameter int KMAX       = knsl_pkg::KMAX_DEF,
    parameter int DIMS       = knsl_pkg::DIMS_DEF,
    parameter int COORD_BITS = knsl_pkg::COORD_BITS_DEF,
    localparam int IN_W        = knsl_pkg::ID_W + DIMS * COORD_BITS,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = knsl_pkg::RANK_W + knsl_pkg::ID_W + knsl_pkg::DIST_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8,
    localparam int CFG_W       = (COORD_BITS > knsl_pkg::KUSED_W) ? COORD_BITS
                                                                  : knsl_pkg::KUSED_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // point_id, coord_0 .. coord_DIMS-1
    input  logic [IN_TDATA_W-1:0]         i_s_axis_tdata,
    // first
    input  logic [0:0]                    i_s_axis_tuser,
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // rank, neighbour_id, distance_sq
    output logic [OUT_TDATA_W-1:0]        o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [knsl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    localparam int KW = $clog2(KMAX + 1);
    localparam int SQ_W = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;

    logic [COORD_BITS-1:0]        r_query [knsl_pkg::QUERY_NUM];
    logic [knsl_pkg::KUSED_W-1:0] r_k_used;
    logic [KW-1:0]                k_eff;

    logic                         r_v1, r_v2, r_v3;
    knsl_pkg::t_tag               n_tag0, r_tag1, r_tag2;
    knsl_pkg::t_cand              r_cand3;
    logic                         en;
    logic                         step;
    logic [SQ_W-1:0]              sq [DIMS];
    logic [SUM_W-1:0]             sum;
    logic [knsl_pkg::DIST_W-1:0]  n_dist;

    knsl_pkg::t_entry [KMAX-1:0]  list_nxt;
    logic [KW-1:0]                fill_nxt;
    logic                         emit_busy;
    logic [knsl_pkg::RANK_W-1:0]  out_rank;
    logic [knsl_pkg::ID_W-1:0]    out_id;
    logic [knsl_pkg::DIST_W-1:0]  out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < knsl_pkg::QUERY_NUM; d++) begin
                r_query[d] <= '0;
            end
            r_k_used <= knsl_pkg::KUSED_RST;
        end else if (i_cfg_we) begin
            case (knsl_pkg::t_cfg_reg'(i_cfg_idx))
                knsl_pkg::CFG_QUERY_0: r_query[0] <= i_cfg_data[COORD_BITS-1:0];
                knsl_pkg::CFG_QUERY_1: r_query[1] <= i_cfg_data[COORD_BITS-1:0];
                knsl_pkg::CFG_QUERY_2: r_query[2] <= i_cfg_data[COORD_BITS-1:0];
                knsl_pkg::CFG_K_USED:  r_k_used   <= i_cfg_data[knsl_pkg::KUSED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_k_used == '0) begin
            k_eff = KW'(1);
        end else if (int'(r_k_used) > KMAX) begin
            k_eff = KW'(KMAX);
        end else begin
            k_eff = KW'(r_k_used);
        end
    end

    assign en   = !(r_v3 && r_cand3.tag.last && emit_busy);
    assign step = r_v3 && en;
    assign o_s_axis_tready = en;

    always_comb begin
        n_tag0.first = i_s_axis_tuser[0];
        n_tag0.last  = i_s_axis_tlast;
        n_tag0.id    = i_s_axis_tdata[knsl_pkg::ID_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag1          <= n_tag0;
            r_tag2          <= r_tag1;
            r_cand3.tag     <= r_tag2;
            r_cand3.dist_sq <= n_dist;
        end
    end

    for (genvar d = 0; d < DIMS; d++) begin : g_lane
        knsl_dist_lane #(
            .COORD_BITS(COORD_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_coord (i_s_axis_tdata[knsl_pkg::ID_W + d*COORD_BITS +: COORD_BITS]),
            .i_query (r_query[d]),
            .o_sq    (sq[d])
        );
    end

    always_comb begin
        sum = '0;
        for (int d = 0; d < DIMS; d++) begin
            sum = SUM_W'(sum + SUM_W'(sq[d]));
        end
        // saturate at the top of the distance range
        if ((sum >> knsl_pkg::DIST_W) != '0) begin
            n_dist = '1;
        end else begin
            n_dist = knsl_pkg::DIST_W'(sum);
        end
    end

    knsl_sorted_list #(
        .KMAX(KMAX)
    ) u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cand  (r_cand3),
        .i_k     (k_eff),
        .o_list  (list_nxt),
        .o_fill  (fill_nxt)
    );

    knsl_emit #(
        .KMAX(KMAX)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && r_cand3.tag.last),
        .i_list  (list_nxt),
        .i_count (fill_nxt),
        .o_busy  (emit_busy),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_rank  (out_rank),
        .o_id    (out_id),
        .o_dist  (out_dist),
        .o_end   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({out_dist, out_id, out_rank});

endmodule
